FILE: rtl/gcr_pkg.sv
`default_nettype none
package gcr_pkg;

    localparam int unsigned SECTOR_BYTES = 256;
    localparam int unsigned GROUP_BYTES  = 5;
    localparam int unsigned FIFO_DEPTH   = 4;
    localparam int unsigned FIFO_PTR_W   = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] SYNC_CODE = 8'hFF;
    localparam logic [7:0] GAP_CODE  = 8'h55;
    localparam logic [7:0] HDR_MARK  = 8'h08;
    localparam logic [7:0] DATA_MARK = 8'h07;
    localparam logic [7:0] HDR_PAD   = 8'h0F;

    localparam logic [4:0] GCR_TABLE [16] = '{
        5'h0A, 5'h0B, 5'h12, 5'h13, 5'h0E, 5'h0F, 5'h16, 5'h17,
        5'h09, 5'h19, 5'h1A, 5'h1B, 5'h0D, 5'h1D, 5'h1E, 5'h15
    };

    typedef enum logic [1:0] {
        CMD_HEADER = 2'd0,
        CMD_GROUP  = 2'd1,
        CMD_LAST   = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [31:0] word;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_status_t;

    function automatic logic [39:0] gcr_encode(input logic [31:0] w);
        logic [39:0] res;
        res = '0;
        for (int i = 0; i < 8; i++)
        begin
            res[39 - 5 * i -: 5] = GCR_TABLE[w[31 - 4 * i -: 4]];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/gcr_in_if.sv
`default_nettype none
interface gcr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [4:0] sector_number;
    logic [5:0] track_number;

    modport source (output valid, output data_byte, output sector_number,
                    output track_number, input ready);
    modport sink (input valid, input data_byte, input sector_number,
                  input track_number, output ready);
endinterface
`default_nettype wire

FILE: rtl/gcr_out_if.sv
`default_nettype none
interface gcr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] coded_byte;
    logic       sync_mark;
    logic       last_of_run;

    modport source (output valid, output coded_byte, output sync_mark,
                    output last_of_run, input ready);
    modport sink (input valid, input coded_byte, input sync_mark,
                  input last_of_run, output ready);
endinterface
`default_nettype wire

FILE: rtl/gcr_front.sv
`default_nettype none
module gcr_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    gcr_in_if.sink                     in_ch,
    input  wire logic [7:0]            disk_id_first,
    input  wire logic [7:0]            disk_id_second,
    input  wire gcr_pkg::fifo_status_t stat,
    output logic                       push,
    output gcr_pkg::cmd_t              push_cmd
);
    import gcr_pkg::*;

    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  chk_reg, chk_next;
    logic [23:0] grp_reg, grp_next;
    logic        accept;
    logic [7:0]  chk_base;
    logic [23:0] grp_base;
    logic [7:0]  hdr_chk;
    logic        first_byte;
    logic        last_byte;
    logic        group_end;

    assign in_ch.ready = !stat.full;
    assign accept      = in_ch.valid && in_ch.ready;
    assign first_byte  = (pos_reg == 8'd0);
    assign last_byte   = (pos_reg == 8'(SECTOR_BYTES - 1));
    assign group_end   = (pos_reg[1:0] == 2'd2);

    assign hdr_chk = {3'b000, in_ch.sector_number} ^ {2'b00, in_ch.track_number}
                   ^ disk_id_second ^ disk_id_first;

    always_comb
    begin
        chk_base = first_byte ? 8'h00 : chk_reg;
        grp_base = first_byte ? {16'h0000, DATA_MARK} : grp_reg;
        chk_next = chk_reg;
        grp_next = grp_reg;
        pos_next = pos_reg;
        push     = 1'b0;
        push_cmd = '{kind: CMD_GROUP, word: {grp_base, in_ch.data_byte}};
        if (accept)
        begin
            chk_next = chk_base ^ in_ch.data_byte;
            pos_next = pos_reg + 8'd1;
            if (first_byte)
            begin
                push     = 1'b1;
                push_cmd = '{kind: CMD_HEADER,
                             word: {HDR_MARK, hdr_chk, 3'b000, in_ch.sector_number,
                                    2'b00, in_ch.track_number}};
                grp_next = {grp_base[15:0], in_ch.data_byte};
            end
            else if (last_byte)
            begin
                push     = 1'b1;
                push_cmd = '{kind: CMD_LAST, word: {in_ch.data_byte, chk_next, 16'h0000}};
                grp_next = '0;
            end
            else if (group_end)
            begin
                push     = 1'b1;
                grp_next = '0;
            end
            else
            begin
                grp_next = {grp_base[15:0], in_ch.data_byte};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            chk_reg <= '0;
            grp_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            chk_reg <= chk_next;
            grp_reg <= grp_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/gcr_fifo.sv
`default_nettype none
module gcr_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire gcr_pkg::cmd_t        push_cmd,
    input  wire logic                 pop,
    output gcr_pkg::cmd_t             head,
    output gcr_pkg::fifo_status_t     stat
);
    import gcr_pkg::*;

    cmd_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;

    assign stat = '{empty: (cnt_reg == '0),
                    full:  (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH))};
    assign head = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && stat.full && !pop))
        else $error("push into full command queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && stat.empty))
        else $error("pop from empty command queue");

    a_count_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("queue count out of step with pop");

endmodule
`default_nettype wire

FILE: rtl/gcr_back.sv
`default_nettype none
module gcr_back #(
    parameter int unsigned SYNC_BYTES = 10,
    parameter int unsigned GAP_BYTES  = 9
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire gcr_pkg::cmd_t         head,
    input  wire gcr_pkg::fifo_status_t stat,
    input  wire logic [7:0]            disk_id_first,
    input  wire logic [7:0]            disk_id_second,
    output logic                       pop,
    gcr_out_if.source                  out_ch
);
    import gcr_pkg::*;

    localparam int unsigned MAX_RUN_A = (SYNC_BYTES > GAP_BYTES) ? SYNC_BYTES : GAP_BYTES;
    localparam int unsigned MAX_RUN   = (MAX_RUN_A > GROUP_BYTES) ? MAX_RUN_A : GROUP_BYTES;
    localparam int unsigned CNT_W     = $clog2(MAX_RUN);
    localparam logic [CNT_W-1:0] SYNC_END  = CNT_W'(SYNC_BYTES - 1);
    localparam logic [CNT_W-1:0] GAP_END   = CNT_W'(GAP_BYTES - 1);
    localparam logic [CNT_W-1:0] GROUP_END = CNT_W'(GROUP_BYTES - 1);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SYNC_A = 8'b0000_0010,
        ST_HDR_A  = 8'b0000_0100,
        ST_HDR_B  = 8'b0000_1000,
        ST_GAP_A  = 8'b0001_0000,
        ST_SYNC_B = 8'b0010_0000,
        ST_DATA   = 8'b0100_0000,
        ST_TAIL   = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [39:0]      sh_reg, sh_next;
    logic             tail_reg, tail_next;
    logic             ov_reg, ov_next;
    logic [7:0]       ob_reg, ob_next;
    logic             os_reg, os_next;
    logic             ol_reg, ol_next;
    logic             fire;

    assign fire = (state_reg != ST_IDLE) && (!ov_reg || out_ch.ready);

    assign out_ch.valid       = ov_reg;
    assign out_ch.coded_byte  = ob_reg;
    assign out_ch.sync_mark   = os_reg;
    assign out_ch.last_of_run = ol_reg;

    always_comb
    begin
        logic [7:0] e_byte;
        logic       e_sync;
        logic       e_last;
        logic [39:0] shifted;
        e_byte     = sh_reg[39:32];
        e_sync     = 1'b0;
        e_last     = 1'b0;
        shifted    = {sh_reg[31:0], 8'h00};
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sh_next    = sh_reg;
        tail_next  = tail_reg;
        pop        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!stat.empty)
                begin
                    pop        = 1'b1;
                    sh_next    = gcr_encode(head.word);
                    cnt_next   = '0;
                    tail_next  = (head.kind == CMD_LAST);
                    state_next = (head.kind == CMD_HEADER) ? ST_SYNC_A : ST_DATA;
                end
            end
            ST_SYNC_A:
            begin
                e_byte = SYNC_CODE;
                e_sync = 1'b1;
                if (fire)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == SYNC_END)
                    begin
                        cnt_next   = '0;
                        state_next = ST_HDR_A;
                    end
                end
            end
            ST_HDR_A:
            begin
                if (fire)
                begin
                    sh_next  = shifted;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == GROUP_END)
                    begin
                        cnt_next   = '0;
                        sh_next    = gcr_encode({disk_id_second, disk_id_first,
                                                 HDR_PAD, HDR_PAD});
                        state_next = ST_HDR_B;
                    end
                end
            end
            ST_HDR_B:
            begin
                if (fire)
                begin
                    sh_next  = shifted;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == GROUP_END)
                    begin
                        cnt_next   = '0;
                        state_next = ST_GAP_A;
                    end
                end
            end
            ST_GAP_A:
            begin
                e_byte = GAP_CODE;
                if (fire)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == GAP_END)
                    begin
                        cnt_next   = '0;
                        state_next = ST_SYNC_B;
                    end
                end
            end
            ST_SYNC_B:
            begin
                e_byte = SYNC_CODE;
                e_sync = 1'b1;
                e_last = (cnt_reg == SYNC_END);
                if (fire)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == SYNC_END)
                    begin
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DATA:
            begin
                e_last = (cnt_reg == GROUP_END) && !tail_reg;
                if (fire)
                begin
                    sh_next  = shifted;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == GROUP_END)
                    begin
                        cnt_next   = '0;
                        state_next = tail_reg ? ST_TAIL : ST_IDLE;
                    end
                end
            end
            ST_TAIL:
            begin
                e_byte = GAP_CODE;
                e_last = (cnt_reg == GAP_END);
                if (fire)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == GAP_END)
                    begin
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase

        ov_next = ov_reg && !out_ch.ready;
        ob_next = ob_reg;
        os_next = os_reg;
        ol_next = ol_reg;
        if (fire)
        begin
            ov_next = 1'b1;
            ob_next = e_byte;
            os_next = e_sync;
            ol_next = e_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            tail_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            tail_reg  <= tail_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
        ob_reg <= ob_next;
        os_reg <= os_next;
        ol_reg <= ol_next;
    end

    function automatic logic e_last_check();
        return (state_reg == ST_SYNC_B && cnt_reg == SYNC_END)
            || (state_reg == ST_TAIL && cnt_reg == GAP_END)
            || (state_reg == ST_DATA && cnt_reg == GROUP_END && !tail_reg);
    endfunction

    a_sync_is_ff: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && os_reg) |-> (ob_reg == SYNC_CODE))
        else $error("sync byte carries a value other than the sync code");

    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == ST_SYNC_A || state_reg == ST_DATA))
        else $error("popped command did not start a run");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && e_last_check()) |=> (state_reg == ST_IDLE && ol_reg))
        else $error("final byte of a run did not close it");

endmodule
`default_nettype wire

FILE: rtl/gcr_sector_frame_encoder_unit.sv
`default_nettype none
// GCR sector frame encoder.
// in_ch takes one sector data byte per item, from byte 0 to byte 255; the
// sector and track fields are sampled with byte 0 only. out_ch gives the disk
// byte stream, one byte per item, with sync_mark on sync bytes and
// last_of_run on the final byte caused by an input item.
// Byte 0 causes 2*SYNC_BYTES + 10 + GAP_BYTES bytes (sync, coded header,
// gap, sync); bytes 2, 6, 10 up to 254 each cause one five-byte GCR group,
// byte 255 a group plus GAP_BYTES tail gap bytes; other bytes cause none.
// The front end accepts one item per cycle, while the queue is not full, into
// a four-entry command queue; the back end sequencer emits one output byte per
// cycle while out_ch is ready, and returns to idle to fetch each command. The
// first output byte passes the queue, the sequencer state and the output register.
// The disk id registers sit on the APB port (0x0: first id, 0x4: second id).
// Reset clears the sector position: the next item starts a new sector.
// A stall on out_ch holds the output register; the queue keeps taking items
// until it fills, then in_ch.ready drops.
module gcr_sector_frame_encoder_unit #(
    parameter int unsigned SYNC_BYTES = 10,
    parameter int unsigned GAP_BYTES  = 9
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    gcr_in_if.sink           in_ch,
    gcr_out_if.source        out_ch
);
    import gcr_pkg::*;

    logic [7:0]   disk_id_first_reg, disk_id_first_next;
    logic [7:0]   disk_id_second_reg, disk_id_second_next;
    logic         cfg_write;
    logic         push;
    logic         pop;
    cmd_t         push_cmd;
    cmd_t         head;
    fifo_status_t stat;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = paddr[2] ? {24'h0, disk_id_second_reg} : {24'h0, disk_id_first_reg};

    always_comb
    begin
        disk_id_first_next  = disk_id_first_reg;
        disk_id_second_next = disk_id_second_reg;
        if (cfg_write)
        begin
            if (paddr[2])
            begin
                disk_id_second_next = pwdata[7:0];
            end
            else
            begin
                disk_id_first_next = pwdata[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_id_first_reg  <= '0;
            disk_id_second_reg <= '0;
        end
        else
        begin
            disk_id_first_reg  <= disk_id_first_next;
            disk_id_second_reg <= disk_id_second_next;
        end
    end

    gcr_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (in_ch),
        .disk_id_first  (disk_id_first_reg),
        .disk_id_second (disk_id_second_reg),
        .stat           (stat),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    gcr_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (stat)
    );

    gcr_back #(
        .SYNC_BYTES (SYNC_BYTES),
        .GAP_BYTES  (GAP_BYTES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .stat           (stat),
        .disk_id_first  (disk_id_first_reg),
        .disk_id_second (disk_id_second_reg),
        .pop            (pop),
        .out_ch         (out_ch)
    );

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gcr_pkg::*;

    localparam int SYNC_RUN = 10;
    localparam int GAP_LEN = 9;
    localparam int PHASES = 5;
    localparam int PHASE_ITEMS = 62;
    localparam int PAUSE_AT = 31;
    localparam int DRAIN_CYCLES = 20;
    localparam int STALL_LIMIT = 3000;
    localparam int SHOWN_MISMATCHES = 10;

    localparam logic [2:0] ADDR_DISK_ID_FIRST = 3'd0;
    localparam logic [2:0] ADDR_DISK_ID_SECOND = 3'd4;

    localparam logic [7:0] EDGE_BYTES [16] = '{
        8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
        8'h40, 8'h80, 8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF
    };
    localparam logic [7:0] PHASE_ID_FIRST [PHASES] = '{8'h00, 8'hFF, 8'h81, 8'h00, 8'hFF};
    localparam logic [7:0] PHASE_ID_SECOND [PHASES] = '{8'h00, 8'hFF, 8'h7E, 8'h00, 8'h00};
    localparam logic [4:0] PHASE_SECTOR [PHASES] = '{5'd0, 5'd20, 5'd31, 5'd0, 5'd31};
    localparam logic [5:0] PHASE_TRACK [PHASES] = '{6'd1, 6'd35, 6'd63, 6'd1, 6'd0};
    localparam int PHASE_SEND_IDLE [PHASES] = '{0, 67, 0, 24, 67};
    localparam int PHASE_STALL [PHASES] = '{0, 0, 67, 24, 67};

    typedef struct packed {
        logic [7:0] coded;
        logic       sync;
        logic       last;
    } disk_byte_t;

    class gcr_frame_tracker;
        logic [7:0]  id_first;
        logic [7:0]  id_second;
        logic [7:0]  byte_pos;
        logic [7:0]  checksum;
        logic [23:0] partial;
        disk_byte_t  pending_bytes[$];
        int          mismatches;

        function new();
            id_first = '0;
            id_second = '0;
            byte_pos = '0;
            checksum = '0;
            partial = '0;
            mismatches = 0;
        endfunction

        function void set_disk_ids(input logic [7:0] first, input logic [7:0] second);
            id_first = first;
            id_second = second;
        endfunction

        function int pending_count();
            return pending_bytes.size();
        endfunction

        function void report(input string what, input logic [31:0] want,
                             input logic [31:0] got);
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
            begin
                $display("mismatch %s: expected %0h, got %0h", what, want, got);
            end
        endfunction

        function logic [4:0] nibble_code(input logic [3:0] nib);
            case (nib)
                4'h0: return 5'h0A;
                4'h1: return 5'h0B;
                4'h2: return 5'h12;
                4'h3: return 5'h13;
                4'h4: return 5'h0E;
                4'h5: return 5'h0F;
                4'h6: return 5'h16;
                4'h7: return 5'h17;
                4'h8: return 5'h09;
                4'h9: return 5'h19;
                4'hA: return 5'h1A;
                4'hB: return 5'h1B;
                4'hC: return 5'h0D;
                4'hD: return 5'h1D;
                4'hE: return 5'h1E;
                default: return 5'h15;
            endcase
        endfunction

        function void push_fill(input logic [7:0] v, input logic sync, input int count);
            disk_byte_t b;
            b.coded = v;
            b.sync = sync;
            b.last = 1'b0;
            repeat (count) pending_bytes.push_back(b);
        endfunction

        function void push_group(input logic [31:0] grp);
            logic [39:0] bits;
            bits = '0;
            for (int i = 0; i < 8; i++)
            begin
                bits = {bits[34:0], nibble_code(grp[31 - 4 * i -: 4])};
            end
            for (int i = 0; i < 5; i++)
            begin
                push_fill(bits[39 - 8 * i -: 8], 1'b0, 1);
            end
        endfunction

        function void take_data_byte(input logic [7:0] d, input logic [4:0] sec,
                                     input logic [5:0] trk);
            int         queued;
            logic [7:0] sec8;
            logic [7:0] trk8;
            logic [7:0] chk;
            disk_byte_t tail;
            queued = pending_bytes.size();
            sec8 = {3'b000, sec};
            trk8 = {2'b00, trk};
            if (byte_pos == 8'd0)
            begin
                chk = sec8 ^ trk8 ^ id_second ^ id_first;
                push_fill(SYNC_CODE, 1'b1, SYNC_RUN);
                push_group({HDR_MARK, chk, sec8, trk8});
                push_group({id_second, id_first, HDR_PAD, HDR_PAD});
                push_fill(GAP_CODE, 1'b0, GAP_LEN);
                push_fill(SYNC_CODE, 1'b1, SYNC_RUN);
                checksum = '0;
                partial = {16'h0000, DATA_MARK};
            end
            checksum = checksum ^ d;
            if (byte_pos == 8'(SECTOR_BYTES - 1))
            begin
                push_group({d, checksum, 16'h0000});
                push_fill(GAP_CODE, 1'b0, GAP_LEN);
                partial = '0;
            end
            else if (byte_pos[1:0] == 2'd2)
            begin
                push_group({partial, d});
                partial = '0;
            end
            else
            begin
                partial = {partial[15:0], d};
            end
            byte_pos = byte_pos + 8'd1;
            if (pending_bytes.size() > queued)
            begin
                tail = pending_bytes.pop_back();
                tail.last = 1'b1;
                pending_bytes.push_back(tail);
            end
        endfunction

        function void check_coded_byte(input logic [7:0] coded, input logic sync,
                                       input logic last);
            disk_byte_t want;
            if (pending_bytes.size() == 0)
            begin
                report("byte with none expected", '0, {22'h0, sync, last, coded});
                return;
            end
            want = pending_bytes.pop_front();
            if (coded !== want.coded) report("coded_byte", {24'h0, want.coded}, {24'h0, coded});
            if (sync !== want.sync) report("sync_mark", {31'h0, want.sync}, {31'h0, sync});
            if (last !== want.last) report("last_of_run", {31'h0, want.last}, {31'h0, last});
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          send_idle_pct;
    int          stall_pct;
    int          quiet_cycles;

    gcr_frame_tracker board;

    gcr_in_if in_ch ();
    gcr_out_if out_ch ();

    gcr_sector_frame_encoder_unit #(
        .SYNC_BYTES(SYNC_RUN),
        .GAP_BYTES(GAP_LEN)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .in_ch(in_ch),
        .out_ch(out_ch)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            board.check_coded_byte(out_ch.coded_byte, out_ch.sync_mark, out_ch.last_of_run);
        end
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reg_read_check(input logic [2:0] addr, input logic [31:0] want);
        logic [31:0] got;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== want) board.report("prdata", want, got);
        @(posedge clk);
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (board.pending_count() != 0);
    endtask

    task automatic send_data_byte(input logic [7:0] d, input logic [4:0] sec,
                                  input logic [5:0] trk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= d;
        in_ch.sector_number <= sec;
        in_ch.track_number <= trk;
        do @(posedge clk); while (!in_ch.ready);
        board.take_data_byte(d, sec, trk);
    endtask

    initial
    begin
        logic [7:0] first_id;
        logic [7:0] second_id;
        logic [7:0] d;
        logic [4:0] sec;
        logic [5:0] trk;
        int         sent;
        board = new();
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.sector_number = '0;
        in_ch.track_number = '0;
        out_ch.ready = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            repeat (DRAIN_CYCLES) @(posedge clk);
            first_id = PHASE_ID_FIRST[ph];
            second_id = PHASE_ID_SECOND[ph];
            if (ph == 3)
            begin
                first_id = 8'($urandom_range(255));
                second_id = 8'($urandom_range(255));
            end
            reg_write(ADDR_DISK_ID_FIRST, {24'h0, first_id});
            reg_write(ADDR_DISK_ID_SECOND, {24'h0, second_id});
            board.set_disk_ids(first_id, second_id);
            reg_read_check(ADDR_DISK_ID_FIRST, {24'h0, first_id});
            reg_read_check(ADDR_DISK_ID_SECOND, {24'h0, second_id});
            send_idle_pct = PHASE_SEND_IDLE[ph];
            stall_pct = PHASE_STALL[ph];

            for (int pos = 0; pos < PHASE_ITEMS; pos++)
            begin
                if ((ph == 1 || ph == 3) && pos == PAUSE_AT)
                begin
                    in_ch.valid <= 1'b0;
                    wait_drained();
                end
                d = 8'($urandom_range(255));
                sec = 5'($urandom_range(31));
                trk = 6'($urandom_range(63));
                if (ph == 0 && pos < 16) d = EDGE_BYTES[pos];
                if ((sent % SECTOR_BYTES) == SECTOR_BYTES - 1) d = ph[0] ? 8'hFF : 8'h00;
                if ((sent % SECTOR_BYTES) == 0)
                begin
                    sec = PHASE_SECTOR[ph];
                    trk = PHASE_TRACK[ph];
                    if (ph == 3)
                    begin
                        sec = 5'($urandom_range(20));
                        trk = 6'($urandom_range(1, 35));
                    end
                end
                send_data_byte(d, sec, trk);
                sent++;
            end
            in_ch.valid <= 1'b0;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.pending_count() != 0)
        begin
            board.report("bytes never produced", board.pending_count(), 0);
        end
        if (board.mismatches == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/gcr_pkg.sv
rtl/gcr_in_if.sv
rtl/gcr_out_if.sv
rtl/gcr_front.sv
rtl/gcr_fifo.sv
rtl/gcr_back.sv
rtl/gcr_sector_frame_encoder_unit.sv
dv/tb_top.sv
